>>> hdl/migc_pkg.sv
// ----------------------------------------------------------------------------
// migc_pkg
// Shared types and constants for the motion intensity gesture classifier.
// ----------------------------------------------------------------------------
package migc_pkg;

  // Ring and sample geometry
  localparam int Depth      = 32;
  localparam int SampleBits = 10;
  localparam int AddrW      = $clog2(Depth);
  localparam int CntW       = $clog2(Depth + 1);
  localparam int SampleW    = 3 * SampleBits;
  localparam int InDataW    = ((SampleW + 7) / 8) * 8;

  // Square root: radicand is the squared distance in Q.16
  localparam int RadW  = 2 * SampleBits + 2 + 16;
  localparam int RootW = RadW / 2;
  localparam int RemW  = RootW + 3;

  // Sum of up to Depth-1 roots and its restoring division
  localparam int SumW  = RootW + AddrW;
  localparam int StepW = $clog2(SumW);

  // Result field widths
  localparam int ClassW   = 2;
  localparam int ThreshW  = 19;
  localparam int ConfW    = 7;
  localparam int HeldW    = 6;
  localparam int OutRawW  = ClassW + ThreshW + ConfW + HeldW;
  localparam int OutDataW = ((OutRawW + 7) / 8) * 8;

  localparam int MinSamples = 3;

  // Confidence per class, percent
  localparam logic [ConfW-1:0] ConfNone  = 7'd0;
  localparam logic [ConfW-1:0] ConfIdle  = 7'd90;
  localparam logic [ConfW-1:0] ConfPoint = 7'd60;
  localparam logic [ConfW-1:0] ConfSwing = 7'd80;

  // Configuration registers
  localparam int                 ApbAddrW   = 3;
  localparam logic               RegSwing   = 1'b0;
  localparam logic               RegPoint   = 1'b1;
  localparam logic [ThreshW-1:0] SwingReset = 19'd205;
  localparam logic [ThreshW-1:0] PointReset = 19'd77;

  typedef enum logic [ClassW-1:0] {
    GC_NONE  = 2'd0,
    GC_IDLE  = 2'd1,
    GC_POINT = 2'd2,
    GC_SWING = 2'd3
  } gesture_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_ACCUM,
    ST_DIV_LOAD,
    ST_DIVIDE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;    // write sample, start a new walk
    logic rd;        // read the next older sample
    logic sq_load;   // form squared distance, seed root unit
    logic sq_step;   // one root bit
    logic acc;       // add root to running sum
    logic div_load;  // seed divider
    logic div_step;  // one quotient bit
    logic out_load;  // capture result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic min_ok;     // enough samples to classify
    logic pairs_done;
    logic step_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/migc_ctrl.sv
// ----------------------------------------------------------------------------
// migc_ctrl
// Sequencer: walks sample pairs through square root, then divides the sum.
// ----------------------------------------------------------------------------
module migc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  migc_pkg::dp_stat_t stat_i,
  output migc_pkg::dp_cmd_t  cmd_o
);

  migc_pkg::ctrl_state_e state_q, state_d;
  logic                  done_q, done_d;  // result waiting for the output register

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= migc_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    done_d     = done_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      migc_pkg::ST_IDLE: begin
        if (done_q) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            done_d         = 1'b0;
          end
        end else begin
          in_ready_o   = 1'b1;
          cmd_o.accept = in_valid_i;
          if (in_valid_i) begin
            state_d = migc_pkg::ST_CHECK;
          end
        end
      end
      migc_pkg::ST_CHECK: begin
        if (stat_i.min_ok) begin
          state_d = migc_pkg::ST_READ;
        end else begin
          done_d  = 1'b1;
          state_d = migc_pkg::ST_IDLE;
        end
      end
      migc_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = migc_pkg::ST_SQUARE;
      end
      migc_pkg::ST_SQUARE: begin
        cmd_o.sq_load = 1'b1;
        state_d       = migc_pkg::ST_ROOT;
      end
      migc_pkg::ST_ROOT: begin
        cmd_o.sq_step = 1'b1;
        if (stat_i.step_last) begin
          state_d = migc_pkg::ST_ACCUM;
        end
      end
      migc_pkg::ST_ACCUM: begin
        cmd_o.acc = 1'b1;
        state_d   = stat_i.pairs_done ? migc_pkg::ST_DIV_LOAD : migc_pkg::ST_READ;
      end
      migc_pkg::ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = migc_pkg::ST_DIVIDE;
      end
      migc_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.step_last) begin
          done_d  = 1'b1;
          state_d = migc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = migc_pkg::ST_IDLE;
        done_d  = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/migc_dp.sv
// ----------------------------------------------------------------------------
// migc_dp
// Datapath: sample ring, bit-serial square root, running sum, bit-serial
// divider, classifier and output register.
// ----------------------------------------------------------------------------
module migc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  migc_pkg::dp_cmd_t                 cmd_i,
  output migc_pkg::dp_stat_t                stat_o,
  input  logic [migc_pkg::InDataW-1:0]      in_data_i,
  input  logic [migc_pkg::ThreshW-1:0]      swing_thr_i,
  input  logic [migc_pkg::ThreshW-1:0]      point_thr_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [migc_pkg::OutDataW-1:0]     out_data_o
);

  localparam int SB = migc_pkg::SampleBits;

  // Ring
  logic [migc_pkg::SampleW-1:0] sample_mem [migc_pkg::Depth];
  logic [migc_pkg::SampleW-1:0] rdata_q, cur_q;
  logic [migc_pkg::AddrW-1:0]   wp_q, rd_addr_q;
  logic [migc_pkg::CntW-1:0]    count_q, count_d, pairs_q;

  // Root, sum, divide
  logic [migc_pkg::RadW-1:0]    rad_q;
  logic [migc_pkg::RootW-1:0]   root_q;
  logic [migc_pkg::RemW-1:0]    sq_rem_q;
  logic [migc_pkg::SumW-1:0]    total_q, quot_q;
  logic [migc_pkg::AddrW-1:0]   divisor_q, div_rem_q;
  logic [migc_pkg::StepW-1:0]   step_q;

  // Output
  logic                          out_valid_q;
  logic [migc_pkg::OutDataW-1:0] out_data_q;

  logic [migc_pkg::SampleW-1:0] sample_in;
  logic [SB:0]                  dx, dy, dz;
  logic [2*SB+1:0]              d2;
  logic [migc_pkg::RemW-1:0]    sq_rem_ext, sq_trial;
  logic                         sq_bit;
  logic [migc_pkg::AddrW:0]     div_rem_ext;
  logic                         div_bit;
  logic [migc_pkg::ThreshW-1:0] intensity;
  migc_pkg::gesture_e           gclass;
  logic [migc_pkg::ConfW-1:0]   conf;

  function automatic logic [SB:0] abs_diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
    abs_diff = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  assign sample_in = in_data_i[migc_pkg::SampleW-1:0];
  assign count_d   = (count_q == migc_pkg::CntW'(migc_pkg::Depth)) ? count_q
                                                                     : count_q + 1'b1;

  // Squared distance between the newer sample (cur_q) and the older one read
  assign dx = abs_diff(cur_q[SB-1:0],      rdata_q[SB-1:0]);
  assign dy = abs_diff(cur_q[2*SB-1:SB],   rdata_q[2*SB-1:SB]);
  assign dz = abs_diff(cur_q[3*SB-1:2*SB], rdata_q[3*SB-1:2*SB]);
  assign d2 = (2*SB+2)'(dx * dx) + (2*SB+2)'(dy * dy) + (2*SB+2)'(dz * dz);

  // Digit-by-digit root: two radicand bits in, one root bit out
  assign sq_rem_ext = {sq_rem_q[migc_pkg::RemW-3:0], rad_q[migc_pkg::RadW-1 -: 2]};
  assign sq_trial   = {1'b0, root_q, 2'b01};
  assign sq_bit     = (sq_rem_ext >= sq_trial);

  // Restoring division of the sum
  assign div_rem_ext = {div_rem_q, quot_q[migc_pkg::SumW-1]};
  assign div_bit     = (div_rem_ext >= {1'b0, divisor_q});

  assign intensity = quot_q[migc_pkg::ThreshW-1:0];

  always_comb begin
    if (count_q < migc_pkg::CntW'(migc_pkg::MinSamples)) begin
      gclass = migc_pkg::GC_NONE;
      conf   = migc_pkg::ConfNone;
    end else if (intensity > swing_thr_i) begin
      gclass = migc_pkg::GC_SWING;
      conf   = migc_pkg::ConfSwing;
    end else if (intensity > point_thr_i) begin
      gclass = migc_pkg::GC_POINT;
      conf   = migc_pkg::ConfPoint;
    end else begin
      gclass = migc_pkg::GC_IDLE;
      conf   = migc_pkg::ConfIdle;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_mem[wp_q] <= sample_in;
    end
    if (cmd_i.rd) begin
      rdata_q <= sample_mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      wp_q    <= (wp_q == migc_pkg::AddrW'(migc_pkg::Depth - 1)) ? '0 : wp_q + 1'b1;
      count_q <= count_d;
    end
  end

  // Walk and arithmetic registers, all seeded by commands
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q     <= sample_in;
      rd_addr_q <= (wp_q == '0) ? migc_pkg::AddrW'(migc_pkg::Depth - 1) : wp_q - 1'b1;
      pairs_q   <= count_d - 1'b1;
      total_q   <= '0;
      quot_q    <= '0;
    end
    if (cmd_i.sq_load) begin
      cur_q     <= rdata_q;
      rd_addr_q <= (rd_addr_q == '0) ? migc_pkg::AddrW'(migc_pkg::Depth - 1)
                                     : rd_addr_q - 1'b1;
      pairs_q   <= pairs_q - 1'b1;
      rad_q     <= {d2, 16'd0};
      root_q    <= '0;
      sq_rem_q  <= '0;
      step_q    <= migc_pkg::StepW'(migc_pkg::RootW - 1);
    end
    if (cmd_i.sq_step) begin
      rad_q    <= {rad_q[migc_pkg::RadW-3:0], 2'b00};
      root_q   <= {root_q[migc_pkg::RootW-2:0], sq_bit};
      sq_rem_q <= sq_bit ? sq_rem_ext - sq_trial : sq_rem_ext;
      step_q   <= step_q - 1'b1;
    end
    if (cmd_i.acc) begin
      total_q <= total_q + migc_pkg::SumW'(root_q);
    end
    if (cmd_i.div_load) begin
      quot_q    <= total_q;
      divisor_q <= migc_pkg::AddrW'(count_q - 1'b1);
      div_rem_q <= '0;
      step_q    <= migc_pkg::StepW'(migc_pkg::SumW - 1);
    end
    if (cmd_i.div_step) begin
      quot_q    <= {quot_q[migc_pkg::SumW-2:0], div_bit};
      div_rem_q <= div_bit ? migc_pkg::AddrW'(div_rem_ext - {1'b0, divisor_q})
                           : div_rem_ext[migc_pkg::AddrW-1:0];
      step_q    <= step_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      out_data_q <= migc_pkg::OutDataW'({migc_pkg::HeldW'(count_q), conf, intensity,
                                         gclass});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.min_ok     = (count_q >= migc_pkg::CntW'(migc_pkg::MinSamples));
  assign stat_o.pairs_done = (pairs_q == '0);
  assign stat_o.step_last  = (step_q == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= migc_pkg::CntW'(migc_pkg::Depth))
    else $error("sample count above ring depth");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> divisor_q != '0)
    else $error("division by zero");

  a_intensity_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && stat_o.min_ok) |-> quot_q[migc_pkg::SumW-1:migc_pkg::ThreshW] == '0)
    else $error("mean magnitude exceeds intensity field");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> stat_o.out_free)
    else $error("result loaded over an untaken result");

endmodule

>>> hdl/motion_intensity_gesture_classifier.sv
// ----------------------------------------------------------------------------
// motion_intensity_gesture_classifier
// Accelerometer motion intensity and gesture class over a ring of samples.
// ----------------------------------------------------------------------------
// Each accepted sample is stored in a 32-entry ring, then the held samples are
// walked pair by pair from newest to oldest. Each pair takes a ring read, the
// squared distance, the bit-serial square root and an add to the running sum.
// The sum is then divided by (samples - 1) in a bit-serial divider. While fewer
// than three samples are held, the walk and the divide are skipped. No new sample
// is taken during a walk. The result sits in an output register, so the next
// sample is taken while it waits.
module motion_intensity_gesture_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [migc_pkg::InDataW-1:0]       s_axis_tdata,  // accel_x, accel_y, accel_z
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [migc_pkg::OutDataW-1:0]      m_axis_tdata,  // gesture_class, intensity,
                                                            // confidence_pct, samples_held
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [migc_pkg::ApbAddrW-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [migc_pkg::ThreshW-1:0] swing_thr_q, point_thr_q;
  logic                         cfg_wr;
  logic                         reg_sel;
  migc_pkg::dp_cmd_t            cmd;
  migc_pkg::dp_stat_t           stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swing_thr_q <= migc_pkg::SwingReset;
      point_thr_q <= migc_pkg::PointReset;
    end else if (cfg_wr) begin
      if (reg_sel == migc_pkg::RegSwing) begin
        swing_thr_q <= pwdata[migc_pkg::ThreshW-1:0];
      end else begin
        point_thr_q <= pwdata[migc_pkg::ThreshW-1:0];
      end
    end
  end

  assign prdata = (reg_sel == migc_pkg::RegPoint) ? 32'(point_thr_q) : 32'(swing_thr_q);

  migc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  migc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .swing_thr_i (swing_thr_q),
    .point_thr_i (point_thr_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> tb/gesture_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_result_checker
// Watches the sample, result and register channels of the gesture classifier,
// keeps its own copy of the sample ring and thresholds, predicts each result
// and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module gesture_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [migc_pkg::InDataW-1:0]  s_axis_tdata,   // accel_x, accel_y, accel_z
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [migc_pkg::OutDataW-1:0] m_axis_tdata,   // gesture_class, intensity,
                                                        // confidence_pct, samples_held
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [migc_pkg::ApbAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          pready,
  output int                            fail_count_o,
  output int                            pending_o
);
  import migc_pkg::*;

  localparam int IntensityLo = ClassW;
  localparam int ConfLo      = IntensityLo + ThreshW;
  localparam int HeldLo      = ConfLo + ConfW;

  typedef struct packed {
    gesture_e             cls;
    logic [ThreshW-1:0]   intensity;
    logic [ConfW-1:0]     conf;
    logic [HeldW-1:0]     held;
  } gesture_result_t;

  logic [SampleBits-1:0] ring_x [Depth];
  logic [SampleBits-1:0] ring_y [Depth];
  logic [SampleBits-1:0] ring_z [Depth];
  logic [AddrW-1:0]      next_slot;
  int                    held_count;
  logic [ThreshW-1:0]    swing_lim;
  logic [ThreshW-1:0]    point_lim;
  gesture_result_t       expected_gestures [$];

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 19; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Walks the held pairs newest to oldest; reads the ring after the new write.
  function automatic gesture_result_t predict_gesture();
    gesture_result_t res;
    longint unsigned total;
    longint unsigned quot;
    int cur, prv, dx, dy, dz;
    res.cls       = GC_NONE;
    res.intensity = '0;
    res.conf      = ConfNone;
    res.held      = HeldW'(held_count);
    if (held_count >= MinSamples) begin
      total = 0;
      for (int i = 1; i < held_count; i++) begin
        cur = (int'(next_slot) + Depth - i) % Depth;
        prv = (int'(next_slot) + Depth - i - 1) % Depth;
        dx = int'(ring_x[cur]) - int'(ring_x[prv]);
        dy = int'(ring_y[cur]) - int'(ring_y[prv]);
        dz = int'(ring_z[cur]) - int'(ring_z[prv]);
        total += floor_sqrt(longint'(dx * dx + dy * dy + dz * dz) << 16);
      end
      quot = total / longint'(held_count - 1);
      res.intensity = ThreshW'(quot);
      if (quot > swing_lim) begin
        res.cls  = GC_SWING;
        res.conf = ConfSwing;
      end else if (quot > point_lim) begin
        res.cls  = GC_POINT;
        res.conf = ConfPoint;
      end else begin
        res.cls  = GC_IDLE;
        res.conf = ConfIdle;
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    gesture_result_t want;
    logic [ThreshW-1:0] reg_value;
    if (!rst_ni) begin
      next_slot    = '0;
      held_count   = 0;
      swing_lim    = SwingReset;
      point_lim    = PointReset;
      expected_gestures.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result side first so a sample accepted on this edge cannot match
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_gestures.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_gestures.pop_front();
          if (m_axis_tdata[ClassW-1:0] != want.cls)
            note_mismatch("gesture_class", want.cls, m_axis_tdata[ClassW-1:0]);
          if (m_axis_tdata[IntensityLo +: ThreshW] != want.intensity)
            note_mismatch("intensity", want.intensity,
                          m_axis_tdata[IntensityLo +: ThreshW]);
          if (m_axis_tdata[ConfLo +: ConfW] != want.conf)
            note_mismatch("confidence_pct", want.conf, m_axis_tdata[ConfLo +: ConfW]);
          if (m_axis_tdata[HeldLo +: HeldW] != want.held)
            note_mismatch("samples_held", want.held, m_axis_tdata[HeldLo +: HeldW]);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        ring_x[next_slot] = s_axis_tdata[SampleBits-1:0];
        ring_y[next_slot] = s_axis_tdata[2*SampleBits-1:SampleBits];
        ring_z[next_slot] = s_axis_tdata[3*SampleBits-1:2*SampleBits];
        next_slot = next_slot + 1'b1;
        if (held_count < Depth) held_count++;
        expected_gestures.push_back(predict_gesture());
      end

      if (psel && penable && pready) begin
        reg_value = (paddr[ApbAddrW-1:2] == RegSwing) ? swing_lim : point_lim;
        if (pwrite) begin
          if (paddr[ApbAddrW-1:2] == RegSwing) swing_lim = pwdata[ThreshW-1:0];
          else point_lim = pwdata[ThreshW-1:0];
        end else if (prdata != 32'(reg_value)) begin
          note_mismatch("register read", reg_value, prdata);
        end
      end

      pending_o = expected_gestures.size();
    end
  end

endmodule

>>> tb/motion_intensity_gesture_classifier_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_intensity_gesture_classifier_test
// Drives accelerometer samples and threshold writes into the classifier with
// random idling on both streams; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module motion_intensity_gesture_classifier_test;
  import migc_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 750;
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 70;
  localparam int MaxSample     = (1 << SampleBits) - 1;

  localparam logic [ApbAddrW-1:0] SwingAddr = {RegSwing, 2'b00};
  localparam logic [ApbAddrW-1:0] PointAddr = {RegPoint, 2'b00};

  typedef enum logic [1:0] {
    MOTION_STILL,
    MOTION_DRIFT,
    MOTION_WILD,
    MOTION_RAILS
  } motion_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;   // accel_x, accel_y, accel_z
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;   // gesture_class, intensity, confidence_pct,
                                         // samples_held
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ApbAddrW-1:0]   paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  int                    quiet_cycles;
  logic                  no_idle;
  logic [SampleBits-1:0] cur_x, cur_y, cur_z;

  motion_intensity_gesture_classifier uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gesture_result_checker result_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic [SampleBits-1:0] nudge(input logic [SampleBits-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 4)) - 2;
    if (t < 0) t = 0;
    if (t > MaxSample) t = MaxSample;
    return SampleBits'(t);
  endfunction

  // upper bits of the word are random; the block keeps only the threshold bits
  function automatic logic [31:0] draw_threshold();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(0, 5))
      0:       word[ThreshW-1:0] = '0;
      1:       word[ThreshW-1:0] = '1;
      2:       word[ThreshW-1:0] = ThreshW'($urandom_range(0, 1024));
      3:       word[ThreshW-1:0] = ThreshW'($urandom_range(0, 8192));
      4:       word[ThreshW-1:0] = ThreshW'($urandom_range(0, 131071));
      default: word[ThreshW-1:0] = ThreshW'($urandom_range(0, 524287));
    endcase
    return word;
  endfunction

  task automatic step_motion(input motion_e style);
    case (style)
      MOTION_STILL: ;
      MOTION_DRIFT: begin
        cur_x = nudge(cur_x);
        cur_y = nudge(cur_y);
        cur_z = nudge(cur_z);
      end
      MOTION_WILD: begin
        cur_x = SampleBits'($urandom_range(0, MaxSample));
        cur_y = SampleBits'($urandom_range(0, MaxSample));
        cur_z = SampleBits'($urandom_range(0, MaxSample));
      end
      default: begin
        cur_x = $urandom_range(0, 1) ? SampleBits'(MaxSample) : '0;
        cur_y = $urandom_range(0, 1) ? SampleBits'(MaxSample) : '0;
        cur_z = $urandom_range(0, 1) ? SampleBits'(MaxSample) : '0;
      end
    endcase
  endtask

  // entered and left at a falling edge; tvalid stays up when the next gap is zero
  task automatic send_sample(input int x, input int y, input int z);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = InDataW'({SampleBits'(z), SampleBits'(y), SampleBits'(x)});
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic apb_transfer(input logic write, input logic [ApbAddrW-1:0] addr,
                              input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input logic [31:0] swing_word, input logic [31:0] point_word);
    drain();
    apb_transfer(1'b1, SwingAddr, swing_word);
    apb_transfer(1'b1, PointAddr, point_word);
    apb_transfer(1'b0, SwingAddr, '0);
    apb_transfer(1'b0, PointAddr, '0);
  endtask

  // result sink
  initial begin : sink
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("motion_intensity_gesture_classifier_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    motion_e style;
    int      run_left;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_idle       = 1'b0;
    cur_x         = '0;
    cur_y         = '0;
    cur_z         = '0;
    run_left      = 0;
    style         = MOTION_STILL;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset thresholds read back, then too few samples, then a still window
    configure(32'(SwingReset), 32'(PointReset));
    send_sample(0, 0, 0);
    send_sample(0, 0, 0);
    send_sample(0, 0, 0);

    // intensity landing exactly on each threshold must not cross it
    configure(32'hABC0_0080, 32'hFFF8_0055);
    send_sample(1, 0, 0);
    send_sample(1, 0, 0);
    send_sample(2, 0, 0);
    send_sample(2, 1, 0);
    send_sample(MaxSample, MaxSample, MaxSample);

    configure(32'hFFF8_0000, 32'h7FF8_0000);
    send_sample(MaxSample, MaxSample, MaxSample);
    send_sample(0, 0, 0);

    configure(32'h0007_FFFF, 32'hFFFF_FFFF);
    send_sample(0, 0, 0);
    send_sample(MaxSample, MaxSample, MaxSample);
    send_sample(0, MaxSample, 0);

    configure(32'h0007_FFFF, 32'h0000_0000);
    send_sample(MaxSample, 0, MaxSample);

    configure(32'h0000_00CD, 32'h0000_004D);
    send_sample(MaxSample, 0, 0);
    send_sample(0, MaxSample, 0);
    send_sample(0, 0, MaxSample);
    send_sample(1, 2, 4);
    send_sample(512, 256, 128);
    send_sample(341, 682, 1);

    // each phase waits for every result before new thresholds go in
    for (int phase = 0; phase < RandomPhases; phase++) begin
      configure(draw_threshold(), draw_threshold());
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 23 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (run_left == 0) begin
          style    = motion_e'($urandom_range(0, 3));
          run_left = $urandom_range(8, 40);
        end
        step_motion(style);
        run_left--;
        send_sample(cur_x, cur_y, cur_z);
      end
    end

    drain();
    repeat (TailCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("motion_intensity_gesture_classifier_test passed");
    end else begin
      $display("motion_intensity_gesture_classifier_test failed");
    end
    $finish;
  end

endmodule
